/* sv/nscf_pkg.sv */
// ---------------------------------------------------------------------------
// nscf_pkg
// Shared types, character codes and the hex digit decoder for the NMEA
// sentence checksum framer.
// ---------------------------------------------------------------------------
package nscf_pkg;

    // framing characters
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;

    // max_header_len after reset
    localparam logic [3:0] MAX_HEADER_LEN_RESET = 4'd6;

    // sentence length saturation point
    localparam logic [7:0] LEN_SAT = 8'hFF;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_HEADER,
        PH_BODY,
        PH_HEX1,
        PH_HEX2
    } phase_t;

    typedef enum logic [1:0] {
        ST_MATCH    = 2'd0,
        ST_MISMATCH = 2'd1,
        ST_HDR_LONG = 2'd2,
        ST_BAD_HEX  = 2'd3
    } status_t;

    // one result transaction
    typedef struct packed {
        status_t    status;
        logic [7:0] computed_sum;
        logic [7:0] received_sum;
        logic [3:0] header_length;
        logic [7:0] sentence_length;
    } result_t;

    // decoded hex character
    typedef struct packed {
        logic       ok;
        logic [3:0] value;
    } hex_t;

    function automatic hex_t hex_decode(input logic [7:0] c);
        hex_t h;
        h.ok    = 1'b1;
        h.value = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            h.value = c[3:0];
        end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
            // lower and upper case letters share the low three bits
            h.value = 4'd9 + {1'b0, c[2:0]};
        end else begin
            h.ok = 1'b0;
        end
        return h;
    endfunction

endpackage

/* sv/nscf_core.sv */
// ---------------------------------------------------------------------------
// nscf_core
// Sentence framing state machine: tracks the phase of the current sentence,
// accumulates the XOR checksum and the lengths, and produces one result when
// a sentence completes or fails.
// ---------------------------------------------------------------------------
module nscf_core
    import nscf_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        step,
    input  logic [7:0]  data_byte,
    input  logic [3:0]  max_header_len,
    output logic        res_valid,
    output result_t     res
);

    phase_t     phase_reg, phase_next;
    logic [7:0] xor_reg, xor_next;
    logic [3:0] hdr_cnt_reg, hdr_cnt_next;
    logic [7:0] len_reg, len_next;
    logic [3:0] high_reg, high_next;
    logic [3:0] hdr_seen_reg, hdr_seen_next;

    hex_t       hex;
    logic [7:0] len_bumped;

    assign hex        = hex_decode(data_byte);
    assign len_bumped = (len_reg == LEN_SAT) ? len_reg : len_reg + 8'd1;

    // next state
    always_comb begin
        phase_next    = phase_reg;
        xor_next      = xor_reg;
        hdr_cnt_next  = hdr_cnt_reg;
        len_next      = len_reg;
        high_next     = high_reg;
        hdr_seen_next = hdr_seen_reg;
        if (step) begin
            priority if (data_byte == CH_DOLLAR) begin
                // start or restart a sentence
                phase_next    = PH_HEADER;
                xor_next      = 8'd0;
                hdr_cnt_next  = 4'd0;
                len_next      = 8'd1;
                high_next     = 4'd0;
                hdr_seen_next = 4'd0;
            end else begin
                unique case (phase_reg)
                    PH_HEADER: begin
                        if (hdr_cnt_reg >= max_header_len) begin
                            phase_next = PH_IDLE;
                        end else begin
                            xor_next = xor_reg ^ data_byte;
                            len_next = len_bumped;
                            if (data_byte == CH_COMMA) begin
                                hdr_seen_next = hdr_cnt_reg + 4'd1;
                                phase_next    = PH_BODY;
                            end else begin
                                hdr_cnt_next = hdr_cnt_reg + 4'd1;
                            end
                        end
                    end
                    PH_BODY: begin
                        if (data_byte == CH_STAR) begin
                            phase_next = PH_HEX1;
                        end else begin
                            xor_next = xor_reg ^ data_byte;
                            len_next = len_bumped;
                        end
                    end
                    PH_HEX1: begin
                        if (hex.ok) begin
                            high_next  = hex.value;
                            phase_next = PH_HEX2;
                        end else begin
                            phase_next = PH_IDLE;
                        end
                    end
                    PH_HEX2: begin
                        phase_next = PH_IDLE;
                    end
                    default: begin
                        phase_next = PH_IDLE;
                    end
                endcase
            end
        end
    end

    // result
    always_comb begin
        res_valid           = 1'b0;
        res.status          = ST_MATCH;
        res.computed_sum    = xor_reg;
        res.received_sum    = 8'd0;
        res.header_length   = hdr_seen_reg;
        res.sentence_length = len_reg;
        if (step && data_byte != CH_DOLLAR) begin
            unique case (phase_reg)
                PH_HEADER: begin
                    if (hdr_cnt_reg >= max_header_len) begin
                        res_valid         = 1'b1;
                        res.status        = ST_HDR_LONG;
                        res.header_length = 4'd0;
                    end
                end
                PH_HEX1: begin
                    if (!hex.ok) begin
                        res_valid  = 1'b1;
                        res.status = ST_BAD_HEX;
                    end
                end
                PH_HEX2: begin
                    res_valid = 1'b1;
                    if (!hex.ok) begin
                        res.status       = ST_BAD_HEX;
                        res.received_sum = {high_reg, 4'd0};
                    end else begin
                        res.received_sum = {high_reg, hex.value};
                        res.status = ({high_reg, hex.value} == xor_reg) ? ST_MATCH
                                                                        : ST_MISMATCH;
                    end
                end
                default: begin
                    res_valid = 1'b0;
                end
            endcase
        end
    end

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_IDLE;
            xor_reg      <= 8'd0;
            hdr_cnt_reg  <= 4'd0;
            len_reg      <= 8'd0;
            high_reg     <= 4'd0;
            hdr_seen_reg <= 4'd0;
        end else begin
            phase_reg    <= phase_next;
            xor_reg      <= xor_next;
            hdr_cnt_reg  <= hdr_cnt_next;
            len_reg      <= len_next;
            high_reg     <= high_next;
            hdr_seen_reg <= hdr_seen_next;
        end
    end

endmodule

/* sv/nmea_sentence_checksum_framer_unit.sv */
// ---------------------------------------------------------------------------
// nmea_sentence_checksum_framer_unit
// Path: the byte that ends the sentence goes through the input register
// and the framing update into the result register that drives m_*.
// Throughput: one byte per cycle unless a held result stalls on m_ready.
// Reset: synchronous active-low aresetn returns to idle, clears the pipeline
// and sets max_header_len to 6.
// ---------------------------------------------------------------------------
module nmea_sentence_checksum_framer_unit
    import nscf_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // configuration
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [3:0]  cfg_data,
    // byte stream
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    // results
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [7:0]  m_computed_sum,
    output logic [7:0]  m_received_sum,
    output logic [3:0]  m_header_length,
    output logic [7:0]  m_sentence_length
);

    logic [3:0] max_len_reg;
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       out_valid_reg;
    result_t    out_res_reg;

    logic       advance;
    logic       core_valid;
    result_t    core_res;

    // pipeline moves when the result register is free or draining
    assign advance   = !out_valid_reg || m_ready;
    assign s_ready   = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    // configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_len_reg <= MAX_HEADER_LEN_RESET;
        end else if (cfg_valid && cfg_ready) begin
            max_len_reg <= cfg_data;
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_byte_reg <= s_data_byte;
        end
    end

    nscf_core u_core (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .step           (in_valid_reg && advance),
        .data_byte      (in_byte_reg),
        .max_header_len (max_len_reg),
        .res_valid      (core_valid),
        .res            (core_res)
    );

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= core_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && core_valid) begin
            out_res_reg <= core_res;
        end
    end

    assign m_valid           = out_valid_reg;
    assign m_status          = out_res_reg.status;
    assign m_computed_sum    = out_res_reg.computed_sum;
    assign m_received_sum    = out_res_reg.received_sum;
    assign m_header_length   = out_res_reg.header_length;
    assign m_sentence_length = out_res_reg.sentence_length;

    // a dollar sign never produces a result transaction
    a_dollar_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && advance && in_byte_reg == CH_DOLLAR) |=> !m_valid)
        else $error("result produced by a dollar sign");

    // match status agrees with the sums
    a_match_sums: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_status == ST_MATCH)) |-> (m_computed_sum == m_received_sum))
        else $error("match reported with differing sums");

    a_mismatch_sums: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_status == ST_MISMATCH)) |-> (m_computed_sum != m_received_sum))
        else $error("mismatch reported with equal sums");

    // header failure carries no received sum or header length
    a_hdr_long_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_status == ST_HDR_LONG))
            |-> (m_received_sum == 8'd0 && m_header_length == 4'd0))
        else $error("header failure with nonzero fields");

    // an empty result register never blocks input
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty result register");

endmodule
